[rtl/fsms_pkg.sv]
// Package for the factored second-moment statistics block.
// Holds the item structs, register indexes and the fp32 multiply and add functions.
package fsms_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 4096;

    typedef struct packed {
        logic [31:0] grad_word;
        logic        last_of_shard;
    } fsms_in_t;

    typedef struct packed {
        logic [9:0]  row_index;
        logic [11:0] column_index;
        logic [31:0] row_sum;
        logic [31:0] column_sum;
        logic        invalid;
    } fsms_out_t;

    localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] REG_START_ROW    = 2'd1;
    localparam logic [1:0] REG_START_COLUMN = 2'd2;
    localparam logic [1:0] REG_GRAD_BF16    = 2'd3;

    localparam logic [31:0] FP_EXP_MASK = 32'h7f80_0000;

    // Round to nearest even on a 24-bit significand with guard and sticky.
    function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [11:0] e,
                                            input logic [47:0] m);
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic [24:0] r;
        logic signed [11:0] ee;
        logic [47:0] mm;
        logic [5:0]  sh;
        begin
            ee = e;
            mm = m;
            // m is normalized with leading one at bit 47; e is biased exponent
            if (ee < 12'sd1) begin
                sh = (ee < -12'sd40) ? 6'd48 : 6'(12'sd1 - ee);
                mm = (sh >= 6'd48) ? {47'd0, |m} : ((m >> sh) | {47'd0, |(m & ~({48{1'b1}} << sh))});
                ee = 12'sd0;
            end
            mant = mm[47:24];
            g    = mm[23];
            st   = |mm[22:0];
            r    = {1'b0, mant} + 25'(g & (st | mant[0]));
            if (r[24]) begin
                r  = r >> 1;
                ee = ee + 12'sd1;
            end else if (ee == 12'sd0 && r[23]) begin
                ee = 12'sd1;
            end
            if (ee >= 12'sd255) fp_pack = {sgn, 8'hff, 23'd0};
            else fp_pack = {sgn, ee[7:0], r[22:0]};
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [11:0] e;
        logic        sgn;
        logic [5:0]  lz;
        begin
            ea  = a[30:23];
            eb  = b[30:23];
            sgn = a[31] ^ b[31];
            ma  = {ea != 8'd0, a[22:0]};
            mb  = {eb != 8'd0, b[22:0]};
            if ((ea == 8'hff && a[22:0] != 0) || (eb == 8'hff && b[22:0] != 0)) begin
                fp_mul = 32'h7fc0_0000;
            end else if (ea == 8'hff || eb == 8'hff) begin
                fp_mul = ((ea == 8'hff && ma == 0 && eb == 0 && b[22:0] == 0) ||
                          (eb == 8'hff && mb == 0 && ea == 0 && a[22:0] == 0))
                         ? 32'h7fc0_0000 : {sgn, 8'hff, 23'd0};
            end else if (ma == 24'd0 || mb == 24'd0) begin
                fp_mul = {sgn, 31'd0};
            end else begin
                p  = ma * mb;
                e  = 12'(ea == 0 ? 1 : ea) + 12'(eb == 0 ? 1 : eb) - 12'sd126;
                lz = 6'd0;
                for (int i = 47; i >= 0; i--) begin
                    if (p[i] && lz == 6'd0 && i != 47) lz = 6'(47 - i);
                    if (p[i] && i == 47) break;
                    if (p[i]) break;
                end
                p = p << lz;
                e = e - 12'(lz);
                fp_mul = fp_pack(sgn, e, p);
            end
        end
    endfunction

    // Add of two nonnegative-or-signed fp32 values; callers pass finite squares.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea, eb;
        logic [31:0] x, y;
        logic [49:0] mx, my, s;
        logic [7:0]  d;
        logic signed [11:0] e;
        logic [5:0]  lz;
        logic        sgn;
        begin
            if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
                if (a[30:23] == 8'hff && a[22:0] != 0) fp_add = 32'h7fc0_0000;
                else if (b[30:23] == 8'hff && b[22:0] != 0) fp_add = 32'h7fc0_0000;
                else if (a[30:23] == 8'hff && b[30:23] == 8'hff && a[31] != b[31])
                    fp_add = 32'h7fc0_0000;
                else fp_add = (a[30:23] == 8'hff) ? a : b;
            end else begin
                if (a[30:0] >= b[30:0]) begin x = a; y = b; end
                else begin x = b; y = a; end
                ea  = x[30:23];
                eb  = y[30:23];
                mx  = {1'b0, ea != 0, x[22:0], 25'd0};
                my  = {1'b0, eb != 0, y[22:0], 25'd0};
                d   = (ea == 0 ? 8'd1 : ea) - (eb == 0 ? 8'd1 : eb);
                if (d > 8'd49) my = {49'd0, |my};
                else my = (my >> d) | {49'd0, |(my & ~({50{1'b1}} << d))};
                sgn = x[31];
                s   = (x[31] == y[31]) ? mx + my : mx - my;
                if (s == 50'd0) begin
                    fp_add = {x[31] & y[31], 31'd0};
                end else begin
                    e  = 12'(ea == 0 ? 8'd1 : ea) + 12'sd1;
                    lz = 6'd0;
                    for (int i = 49; i >= 0; i--) begin
                        if (s[i]) begin
                            lz = 6'(49 - i);
                            break;
                        end
                    end
                    s = s << lz;
                    e = e - 12'(lz);
                    fp_add = fp_pack(sgn, e, {s[49:3], |s[2:0]});
                end
            end
        end
    endfunction

endpackage

[rtl/factored_second_moment_stats.sv]
// Factored second-moment statistics: row and column fp32 sums of squares.
// Depends on fsms_pkg. Items pass square, memory read and add stages before the
// result is valid; one item per cycle unless the output or clearing stalls it;
// forwarding covers back-to-back updates. After reset a clearing pass zeroes both
// stores; no item is accepted until it ends. Configuration resets to its listed values.
module factored_second_moment_stats (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fsms_pkg::fsms_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fsms_pkg::fsms_out_t   m_data
);
    import fsms_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int KW = (MAX_ROWS > MAX_COLUMNS) ? RW : CW;
    localparam int KD = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;

    logic [31:0] row_mem [MAX_ROWS];
    logic [31:0] col_mem [MAX_COLUMNS];

    logic [12:0] column_count_reg;
    logic [9:0]  start_row_reg;
    logic [11:0] start_column_reg;
    logic        bf16_reg;

    logic [KW:0] clr_reg;
    logic        clr_busy;
    assign clr_busy = (clr_reg != (KW+1)'(KD));

    logic [16:0] eff_cols;
    logic [16:0] ld_row, ld_col;
    logic [16:0] cur_row_reg, cur_col_reg;
    logic        bad_reg;

    always_comb begin
        eff_cols = (column_count_reg == 13'd0) ? 17'd1 : 17'(column_count_reg);
        if (eff_cols > 17'(MAX_COLUMNS)) eff_cols = 17'(MAX_COLUMNS);
        ld_row = (17'(start_row_reg) < 17'(MAX_ROWS)) ? 17'(start_row_reg) : 17'd0;
        ld_col = (17'(start_column_reg) < eff_cols) ? 17'(start_column_reg) : 17'd0;
    end

    logic cfg_wr;
    logic [1:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            REG_COLUMN_COUNT: prdata = 32'(column_count_reg);
            REG_START_ROW:    prdata = 32'(start_row_reg);
            REG_START_COLUMN: prdata = 32'(start_column_reg);
            REG_GRAD_BF16:    prdata = 32'(bf16_reg);
            default:          prdata = 32'd0;
        endcase
    end

    // Stage 1: square, position. Stage 2: memory read. Stage 3: add, write, output.
    logic        v1_reg, v2_reg;
    logic [31:0] sq1_reg, sq2_reg;
    logic [RW-1:0] r1_reg, r2_reg;
    logic [CW-1:0] c1_reg, c2_reg;
    logic        bad1_reg, bad2_reg;
    logic [31:0] rrd_reg, crd_reg;
    logic        m_valid_reg;
    fsms_out_t   m_data_reg;

    logic adv, out_free;
    assign out_free = ~m_valid_reg | m_ready;
    assign adv      = out_free & ~clr_busy;
    assign s_ready  = adv;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    logic        acc;
    logic [31:0] word, sq_raw, sq;
    logic        sq_bad;
    assign acc = s_valid & s_ready;

    always_comb begin
        word   = bf16_reg ? {s_data.grad_word[15:0], 16'd0} : s_data.grad_word;
        sq_raw = fp_mul(word, word);
        sq_bad = (sq_raw & FP_EXP_MASK) == FP_EXP_MASK;
        sq     = sq_bad ? 32'd0 : sq_raw;
    end

    logic [31:0] row_new, col_new, row_old, col_old;
    always_comb begin
        row_old = rrd_reg;
        col_old = crd_reg;
        if (m_valid_reg && m_data_reg.row_index == 10'(r2_reg))
            row_old = m_data_reg.row_sum;
        if (m_valid_reg && m_data_reg.column_index == 12'(c2_reg))
            col_old = m_data_reg.column_sum;
        row_new = fp_add(row_old, sq2_reg);
        col_new = fp_add(col_old, sq2_reg);
    end

    logic [16:0] nc;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= 13'd4096;
            start_row_reg    <= 10'd0;
            start_column_reg <= 12'd0;
            bf16_reg         <= 1'b0;
            cur_row_reg      <= 17'd0;
            cur_col_reg      <= 17'd0;
            bad_reg          <= 1'b0;
            clr_reg          <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (clr_busy) clr_reg <= clr_reg + 1'b1;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_COLUMN_COUNT: column_count_reg <= pwdata[12:0];
                    REG_START_ROW: begin
                        start_row_reg <= pwdata[9:0];
                        cur_row_reg   <= (17'(pwdata[9:0]) < 17'(MAX_ROWS)) ?
                                         17'(pwdata[9:0]) : 17'd0;
                        cur_col_reg   <= ld_col;
                    end
                    REG_START_COLUMN: begin
                        start_column_reg <= pwdata[11:0];
                        cur_row_reg      <= ld_row;
                        cur_col_reg      <= (17'(pwdata[11:0]) < eff_cols) ?
                                            17'(pwdata[11:0]) : 17'd0;
                    end
                    REG_GRAD_BF16: bf16_reg <= pwdata[0];
                    default: ;
                endcase
            end
            if (adv) begin
                v1_reg <= acc;
                v2_reg <= v1_reg;
                m_valid_reg <= v2_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (acc) begin
                if (s_data.last_of_shard) begin
                    bad_reg     <= 1'b0;
                    cur_row_reg <= ld_row;
                    cur_col_reg <= ld_col;
                end else begin
                    bad_reg <= bad_reg | sq_bad;
                    if (nc >= eff_cols) begin
                        cur_col_reg <= 17'd0;
                        cur_row_reg <= (cur_row_reg + 17'd1 >= 17'(MAX_ROWS)) ?
                                       17'd0 : cur_row_reg + 17'd1;
                    end else begin
                        cur_col_reg <= nc;
                    end
                end
            end
        end
    end

    logic [16:0] r_use, c_use;
    always_comb begin
        r_use = (cur_row_reg >= 17'(MAX_ROWS)) ? 17'd0 : cur_row_reg;
        c_use = (cur_col_reg >= eff_cols) ? 17'd0 : cur_col_reg;
        nc    = c_use + 17'd1;
    end

    // Stage 2 address may match the stage 3 write: forward in stage 2 too.
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_reg  <= sq;
            r1_reg   <= RW'(r_use);
            c1_reg   <= CW'(c_use);
            bad1_reg <= bad_reg | sq_bad;
            sq2_reg  <= sq1_reg;
            r2_reg   <= r1_reg;
            c2_reg   <= c1_reg;
            bad2_reg <= bad1_reg;
            rrd_reg  <= (v2_reg && r2_reg == r1_reg) ? row_new : row_mem[r1_reg];
            crd_reg  <= (v2_reg && c2_reg == c1_reg) ? col_new : col_mem[c1_reg];
            if (v2_reg) begin
                m_data_reg.row_index    <= 10'(r2_reg);
                m_data_reg.column_index <= 12'(c2_reg);
                m_data_reg.row_sum      <= row_new;
                m_data_reg.column_sum   <= col_new;
                m_data_reg.invalid      <= bad2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            if (clr_reg < (KW+1)'(MAX_ROWS)) row_mem[RW'(clr_reg)] <= 32'd0;
            if (clr_reg < (KW+1)'(MAX_COLUMNS)) col_mem[CW'(clr_reg)] <= 32'd0;
        end else if (adv && v2_reg) begin
            row_mem[r2_reg] <= row_new;
            col_mem[c2_reg] <= col_new;
        end
    end

endmodule
